/* rtl/atlb_pkg.sv */
`default_nettype none

package atlb_pkg;

  localparam int DEF_MAX_NODES   = 8;
  localparam int DEF_COUNT_WIDTH = 16;
  localparam int CFG_W           = 4;
  localparam int MARGIN          = 2;

  localparam logic [CFG_W-1:0] NODES_RST = 4'd8;

  typedef enum logic [1:0] {
    FUNC_WRITE   = 2'd0,
    FUNC_READ    = 2'd1,
    FUNC_BALANCE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_XFER = 2'd1,
    KIND_DONE = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_DIV,
    ST_IRD,
    ST_ICHK,
    ST_JRD,
    ST_JCHK,
    ST_IWB,
    ST_DONE
  } state_e;

  typedef struct packed {
    func_e       func;
    logic [2:0]  node_index;
    logic [15:0] task_count_in;
  } req_t;

  typedef struct packed {
    kind_e       kind;
    logic [2:0]  source_node;
    logic [2:0]  dest_node;
    logic [15:0] amount;
    logic [15:0] count_out;
    logic        last;
  } res_t;

endpackage

`default_nettype wire

/* rtl/average_task_load_balancer.sv */
// Channel   Direction  Handshake                  Payload
// command   in         start high, busy low       req_i (req_t)
// result    out        res_valid_o, one cycle     res_o (res_t)
// config    in         cfg_valid_i & cfg_ready_o  cfg_data_i (nodes in use)
//
// A write leaves busy low; a read returns its beat through the table read register
// and then the result register.
// A balance pass sums the table over the n nodes in use, then divides the total by n
// in the bit-serial divider (skipped when n is zero), then checks each node; for each
// overloaded node it scans the receivers, then takes the closing read slot and writes
// the node back; at the end it ends the scan and registers the done beat.
// The task table is read through a register: each count read is used from that register,
// and updated counts are written back to the table.
// Reset clears the valid bits of the table at once, so all counts read as zero.
// The receiver cannot stall; each result beat is shown for exactly one cycle.

`default_nettype none

module average_task_load_balancer
  import atlb_pkg::*;
#(
  parameter int MAX_NODES   = DEF_MAX_NODES,
  parameter int COUNT_WIDTH = DEF_COUNT_WIDTH
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start,
  output logic                  busy,
  input  wire req_t             req_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             cfg_valid_i,
  output logic                  cfg_ready_o,
  input  wire logic [CFG_W-1:0] cfg_data_i
);

  localparam int AW  = $clog2(MAX_NODES);
  localparam int IW  = $clog2(MAX_NODES + 1);
  localparam int TW  = COUNT_WIDTH + AW;
  localparam int MW  = COUNT_WIDTH + AW;
  localparam int DCW = $clog2(TW + 1);
  localparam int OW  = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
  localparam int IXW = (AW > 3) ? AW : 3;

  state_e state_q, state_d;

  logic [CFG_W-1:0]       nodes_q;
  logic [COUNT_WIDTH-1:0] mem_q [MAX_NODES];
  logic [MAX_NODES-1:0]   vld_q;
  logic [COUNT_WIDTH-1:0] rdata_q;
  logic                   rd_vld_q;

  logic [IW-1:0]          n_q, i_q, j_q;
  logic [TW-1:0]          total_q;
  logic [IW-1:0]          rem_q;
  logic [DCW-1:0]         div_cnt_q;
  logic [COUNT_WIDTH-1:0] excess_q, cnt_i_q;
  logic [MW-1:0]          moved_q;
  logic                   pend_q, oob_q;
  logic                   res_valid_q;
  res_t                   res_q, res_d;
  logic                   res_vld_d;

  logic                   rd_en, we;
  logic [AW-1:0]          raddr, waddr;
  logic [COUNT_WIDTH-1:0] wdata;

  logic                   accept;
  logic [COUNT_WIDTH-1:0] cnt_rd, avg, room, xfer;
  logic                   over, under, in_oob;
  logic [IW-1:0]          n_sat;
  logic [IW:0]            trial;
  logic                   qbit;
  logic [OW-1:0]          in_ext, cnt_ext, xfer_ext, sat_ext;
  logic [IXW-1:0]         idx_ext, i_ext, j_ext;
  logic [COUNT_WIDTH-1:0] in_val, moved_sat;
  logic                   sum_done;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  assign cnt_rd = rd_vld_q ? rdata_q : '0;
  assign avg    = total_q[COUNT_WIDTH-1:0];
  assign over   = {1'b0, cnt_rd} > ({1'b0, avg} + (COUNT_WIDTH + 1)'(MARGIN));
  assign under  = cnt_rd < avg;
  assign room   = avg - cnt_rd;
  assign xfer   = (excess_q < room) ? excess_q : room;
  assign in_oob = 32'(req_i.node_index) >= MAX_NODES;
  assign n_sat  = (32'(nodes_q) > MAX_NODES) ? IW'(MAX_NODES) : IW'(nodes_q);
  assign trial  = {rem_q, total_q[TW-1]};
  assign qbit   = trial >= {1'b0, n_q};
  assign sum_done = (i_q == n_q) && !pend_q;

  assign in_ext   = OW'(req_i.task_count_in);
  assign in_val   = in_ext[COUNT_WIDTH-1:0];
  assign cnt_ext  = OW'(cnt_rd);
  assign xfer_ext = OW'(xfer);
  assign moved_sat = (|moved_q[MW-1:COUNT_WIDTH]) ? '1 : moved_q[COUNT_WIDTH-1:0];
  assign sat_ext  = OW'(moved_sat);
  assign idx_ext  = IXW'(req_i.node_index);
  assign i_ext    = IXW'(i_q[AW-1:0]);
  assign j_ext    = IXW'(j_q[AW-1:0]);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (req_i.func)
            FUNC_READ:    state_d = ST_READ;
            FUNC_BALANCE: state_d = ST_SUM;
            default:      state_d = ST_IDLE;
          endcase
        end
      end
      ST_READ: state_d = ST_IDLE;
      ST_SUM: begin
        if (sum_done) begin
          state_d = (n_q == '0) ? ST_IRD : ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_cnt_q == DCW'(1)) begin
          state_d = ST_IRD;
        end
      end
      ST_IRD:  state_d = (i_q == n_q) ? ST_DONE : ST_ICHK;
      ST_ICHK: state_d = over ? ST_JRD : ST_IRD;
      ST_JRD:  state_d = ((j_q == n_q) || (excess_q == '0)) ? ST_IWB : ST_JCHK;
      ST_JCHK: state_d = ST_JRD;
      ST_IWB:  state_d = ST_IRD;
      ST_DONE: state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    rd_en     = 1'b0;
    raddr     = '0;
    we        = 1'b0;
    waddr     = '0;
    wdata     = '0;
    res_d     = '0;
    res_vld_d = 1'b0;
    case (state_q)
      ST_IDLE: begin
        raddr = idx_ext[AW-1:0];
        waddr = idx_ext[AW-1:0];
        wdata = in_val;
        rd_en = accept && (req_i.func == FUNC_READ) && !in_oob;
        we    = accept && (req_i.func == FUNC_WRITE) && !in_oob;
      end
      ST_READ: begin
        res_vld_d       = 1'b1;
        res_d.kind      = KIND_READ;
        res_d.count_out = oob_q ? 16'd0 : cnt_ext[15:0];
        res_d.last      = 1'b1;
      end
      ST_SUM: begin
        raddr = i_q[AW-1:0];
        rd_en = (i_q != n_q);
      end
      ST_IRD: begin
        raddr = i_q[AW-1:0];
        rd_en = (i_q != n_q);
      end
      ST_JRD: begin
        raddr = j_q[AW-1:0];
        rd_en = (j_q != n_q) && (excess_q != '0);
      end
      ST_JCHK: begin
        waddr = j_q[AW-1:0];
        wdata = cnt_rd + xfer;
        if (under) begin
          we                = 1'b1;
          res_vld_d         = 1'b1;
          res_d.kind        = KIND_XFER;
          res_d.source_node = i_ext[2:0];
          res_d.dest_node   = j_ext[2:0];
          res_d.amount      = xfer_ext[15:0];
        end
      end
      ST_IWB: begin
        we    = 1'b1;
        waddr = i_q[AW-1:0];
        wdata = cnt_i_q;
      end
      ST_DONE: begin
        res_vld_d    = 1'b1;
        res_d.kind   = KIND_DONE;
        res_d.amount = sat_ext[15:0];
        res_d.last   = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    if (rd_en) begin
      rdata_q <= mem_q[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      nodes_q     <= NODES_RST;
      vld_q       <= '0;
      rd_vld_q    <= 1'b0;
      res_valid_q <= 1'b0;
      pend_q      <= 1'b0;
    end else begin
      state_q     <= state_d;
      res_valid_q <= res_vld_d;
      pend_q      <= (state_q == ST_SUM) && rd_en;
      if (cfg_valid_i && cfg_ready_o) begin
        nodes_q <= cfg_data_i;
      end
      if (we) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_en) begin
        rd_vld_q <= vld_q[raddr];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          oob_q   <= in_oob;
          n_q     <= n_sat;
          i_q     <= '0;
          total_q <= '0;
          moved_q <= '0;
        end
      end
      ST_SUM: begin
        if (i_q != n_q) begin
          i_q <= i_q + IW'(1);
        end
        if (pend_q) begin
          total_q <= total_q + TW'(cnt_rd);
        end
        if (sum_done) begin
          i_q       <= '0;
          rem_q     <= '0;
          div_cnt_q <= DCW'(TW);
        end
      end
      ST_DIV: begin
        rem_q     <= qbit ? IW'(trial - {1'b0, n_q}) : trial[IW-1:0];
        total_q   <= {total_q[TW-2:0], qbit};
        div_cnt_q <= div_cnt_q - DCW'(1);
      end
      ST_ICHK: begin
        cnt_i_q  <= cnt_rd;
        excess_q <= cnt_rd - avg;
        j_q      <= '0;
        if (!over) begin
          i_q <= i_q + IW'(1);
        end
      end
      ST_JCHK: begin
        if (under) begin
          excess_q <= excess_q - xfer;
          cnt_i_q  <= cnt_i_q - xfer;
          moved_q  <= moved_q + MW'(xfer);
        end
        j_q <= j_q + IW'(1);
      end
      ST_IWB: begin
        i_q <= i_q + IW'(1);
      end
      default: begin
      end
    endcase
  end

`ifndef SYNTHESIS
  a_last_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.last == (res_o.kind != KIND_XFER)))
    else $error("last flag does not match result kind");

  a_busy_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (busy == (res_o.kind == KIND_XFER)))
    else $error("transfer beat outside a balance pass or final beat while busy");

  a_read_lat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == FUNC_READ)) |-> ##2 (res_valid_o && (res_o.kind == KIND_READ)))
    else $error("read beat missing two cycles after the command");

  a_write_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (req_i.func == FUNC_WRITE)) |=> (!busy && !res_valid_o))
    else $error("write command left the block busy or produced a beat");
`endif

endmodule

`default_nettype wire

/* test/average_task_load_balancer_tb.sv */
module average_task_load_balancer_tb;
  import atlb_pkg::*;

  localparam int          N_NODES     = DEF_MAX_NODES;
  localparam int          COUNT_MAX   = (1 << DEF_COUNT_WIDTH) - 1;
  localparam logic [1:0]  FUNC_UNUSED = 2'd3;
  localparam int          REQ_W       = $bits(req_t);
  localparam int unsigned LIMIT       = 400000;
  localparam int          N_ROWS      = 26;
  localparam int          N_ITEMS     = 110;

  typedef enum logic {ROW_CMD, ROW_CFG} row_e;

  typedef struct packed {
    row_e        kind;
    logic [1:0]  func;
    logic [2:0]  idx;
    logic [15:0] val;
    logic        typed;
    logic [15:0] want;
  } row_t;

  logic             clk_i = 1'b0;
  logic             rst_ni;
  logic             start;
  logic             busy;
  req_t             req;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_valid;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data;

  int unsigned task_table [N_NODES];
  int unsigned nodes_cfg;
  res_t        beats_due [$];
  int          errors    = 0;
  int          items     = 0;
  int unsigned cycle_cnt = 0;
  bit          burst     = 1'b0;

  row_t plan [N_ROWS] = '{
    '{ROW_CMD, FUNC_READ,    3'd0, 16'd0,      1'b1, 16'd0},
    '{ROW_CMD, FUNC_READ,    3'd7, 16'd0,      1'b1, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b1, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd0, 16'hFFFF,   1'b0, 16'd0},
    '{ROW_CMD, FUNC_READ,    3'd0, 16'd0,      1'b1, 16'hFFFF},
    '{ROW_CMD, FUNC_UNUSED,  3'd0, 16'd1234,   1'b0, 16'd0},
    '{ROW_CMD, FUNC_READ,    3'd0, 16'd0,      1'b1, 16'hFFFF},
    '{ROW_CMD, FUNC_WRITE,   3'd1, 16'hFFFF,   1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd2, 16'hFFFF,   1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd3, 16'hFFFF,   1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd7, 16'd0,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_READ,    3'd4, 16'd0,      1'b0, 16'd0},
    '{ROW_CFG, FUNC_WRITE,   3'd0, 16'd0,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b1, 16'd0},
    '{ROW_CFG, FUNC_WRITE,   3'd0, 16'd15,     1'b0, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b0, 16'd0},
    '{ROW_CFG, FUNC_WRITE,   3'd0, 16'd1,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd0, 16'd100,    1'b0, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b1, 16'd0},
    '{ROW_CFG, FUNC_WRITE,   3'd0, 16'd3,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd1, 16'd0,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_WRITE,   3'd2, 16'd5,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_BALANCE, 3'd0, 16'd0,      1'b0, 16'd0},
    '{ROW_CFG, FUNC_WRITE,   3'd0, 16'd8,      1'b0, 16'd0},
    '{ROW_CMD, FUNC_READ,    3'd2, 16'd0,      1'b0, 16'd0}
  };

  average_task_load_balancer dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  initial begin
    wait (cycle_cnt >= LIMIT);
    $display("Some tests failed");
    $finish;
  end

  function automatic void model_command(input req_t r);
    res_t        rs;
    int unsigned n, total, avg, moved, excess, room, amt;
    rs = '0;
    case (r.func)
      FUNC_WRITE: begin
        task_table[r.node_index] = 32'(r.task_count_in);
      end
      FUNC_READ: begin
        rs.kind      = KIND_READ;
        rs.count_out = 16'(task_table[r.node_index]);
        rs.last      = 1'b1;
        beats_due.push_back(rs);
      end
      FUNC_BALANCE: begin
        n     = (nodes_cfg > N_NODES) ? N_NODES : nodes_cfg;
        total = 0;
        moved = 0;
        for (int i = 0; i < n; i++) total += task_table[i];
        avg = (n > 0) ? total / n : 0;
        for (int i = 0; i < n; i++) begin
          if (task_table[i] > avg + MARGIN) begin
            excess = task_table[i] - avg;
            for (int j = 0; j < n && excess > 0; j++) begin
              if (task_table[j] < avg) begin
                room = avg - task_table[j];
                amt  = (excess < room) ? excess : room;
                task_table[j] += amt;
                task_table[i] -= amt;
                excess -= amt;
                moved  += amt;
                rs             = '0;
                rs.kind        = KIND_XFER;
                rs.source_node = 3'(i);
                rs.dest_node   = 3'(j);
                rs.amount      = 16'(amt);
                beats_due.push_back(rs);
              end
            end
          end
        end
        rs        = '0;
        rs.kind   = KIND_DONE;
        rs.amount = 16'((moved > COUNT_MAX) ? COUNT_MAX : moved);
        rs.last   = 1'b1;
        beats_due.push_back(rs);
      end
      default: ;
    endcase
  endfunction

  function automatic int pick_gap();
    if (burst || $urandom_range(0, 9) < 5) return 0;
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void flag(input string field, input logic [15:0] e, input logic [15:0] g);
    $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, e, g);
    errors++;
  endfunction

  // Called at a falling edge; leaves start high when the next command follows at once.
  task automatic issue(input req_t r, input bit typed, input logic [15:0] want);
    res_t w;
    int   gap;
    start = 1'b1;
    req   = r;
    do @(posedge clk_i); while (busy);
    model_command(r);
    if (typed) begin
      w      = '0;
      w.kind = (r.func == FUNC_READ) ? KIND_READ : KIND_DONE;
      if (r.func == FUNC_READ) w.count_out = want;
      else w.amount = want;
      w.last = 1'b1;
      beats_due[beats_due.size() - 1] = w;
    end
    if (r.func != FUNC_UNUSED) items++;
    @(negedge clk_i);
    gap = pick_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic drain();
    start = 1'b0;
    while (beats_due.size() != 0 || busy) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_nodes(input logic [CFG_W-1:0] v);
    drain();
    cfg_valid = 1'b1;
    cfg_data  = v;
    do @(posedge clk_i); while (!cfg_ready_o);
    nodes_cfg = 32'(v);
    @(negedge clk_i);
    cfg_valid = 1'b0;
  endtask

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni && res_valid_o) begin
      if (beats_due.size() == 0) begin
        $display("%0t: result beat with none due, actual %p", $time, res_o);
        errors++;
      end else begin
        want = beats_due.pop_front();
        if (res_o.kind !== want.kind) flag("kind", 16'(want.kind), 16'(res_o.kind));
        if (res_o.source_node !== want.source_node)
          flag("source_node", 16'(want.source_node), 16'(res_o.source_node));
        if (res_o.dest_node !== want.dest_node)
          flag("dest_node", 16'(want.dest_node), 16'(res_o.dest_node));
        if (res_o.amount !== want.amount) flag("amount", want.amount, res_o.amount);
        if (res_o.count_out !== want.count_out)
          flag("count_out", want.count_out, res_o.count_out);
        if (res_o.last !== want.last) flag("last", 16'(want.last), 16'(res_o.last));
      end
    end
  end

  initial begin
    req_t r;
    int   spread;
    rst_ni    = 1'b0;
    start     = 1'b0;
    req       = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    foreach (task_table[i]) task_table[i] = 0;
    nodes_cfg = 32'(NODES_RST);
    repeat (4) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    foreach (plan[k]) begin
      if (plan[k].kind == ROW_CFG) begin
        set_nodes(plan[k].val[CFG_W-1:0]);
      end else begin
        r.func          = func_e'(plan[k].func);
        r.node_index    = plan[k].idx;
        r.task_count_in = plan[k].val;
        issue(r, plan[k].typed, plan[k].want);
      end
    end

    while (items < N_ITEMS - 6) begin
      if ($urandom_range(0, 3) == 0) begin
        if ($urandom_range(0, 7) == 0) set_nodes(CFG_W'($urandom_range(0, 15)));
        else set_nodes(CFG_W'($urandom_range(1, 8)));
      end
      burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 4) != 0) begin
        spread = $urandom_range(0, 3);
        repeat ($urandom_range(1, 8)) begin
          r.func       = FUNC_WRITE;
          r.node_index = 3'($urandom_range(0, 7));
          case (spread)
            0: r.task_count_in = 16'($urandom_range(0, 40));
            1: r.task_count_in = 16'($urandom_range(0, COUNT_MAX));
            2: r.task_count_in = $urandom_range(0, 1) ? 16'(COUNT_MAX - $urandom_range(0, 600))
                                                      : 16'($urandom_range(0, 600));
            default: r.task_count_in = 16'(1000 + $urandom_range(0, 60));
          endcase
          issue(r, 1'b0, '0);
        end
        r.func          = FUNC_READ;
        r.node_index    = 3'($urandom_range(0, 7));
        r.task_count_in = 16'($urandom);
        if ($urandom_range(0, 1) == 0) issue(r, 1'b0, '0);
        r.func = FUNC_BALANCE;
        issue(r, 1'b0, '0);
        repeat ($urandom_range(0, 2)) begin
          r.func       = FUNC_READ;
          r.node_index = 3'($urandom_range(0, 7));
          issue(r, 1'b0, '0);
        end
      end else begin
        repeat ($urandom_range(1, 6)) begin
          r = req_t'(REQ_W'($urandom));
          issue(r, 1'b0, '0);
        end
      end
    end

    burst = 1'b0;
    drain();
    repeat (32) @(negedge clk_i);
    if (errors == 0 && beats_due.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* average_task_load_balancer.f */
rtl/atlb_pkg.sv
rtl/average_task_load_balancer.sv
test/average_task_load_balancer_tb.sv
